// ----- sv/shs_pkg.sv -----
`timescale 1ns / 1ps

package shs_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;

  localparam logic [7:0] PadMark = 8'h80;

  // round constants
  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam logic [WordW-1:0] InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // control to the schedule window
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       step;
  } sched_ctl_t;

  // control to the round unit
  typedef struct packed {
    logic init;
    logic step;
  } round_ctl_t;

endpackage

// ----- sv/shs_sched.sv -----
`timescale 1ns / 1ps

module shs_sched (
  input  logic                           clk_i,
  input  shs_pkg::sched_ctl_t            ctl_i,
  output logic [shs_pkg::WordW-1:0]      w0_o
);

  logic [shs_pkg::WordW-1:0] w_q [shs_pkg::BlkWords];
  logic [shs_pkg::WordW-1:0] w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // next schedule word from the sliding window
  always_comb begin
    w_new = w_q[0]
          + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
          + w_q[9]
          + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
  end

  // bytes shift in big-endian, rounds shift a word at a time
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_byte) begin
      for (int i = 0; i < shs_pkg::BlkWords - 1; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[shs_pkg::BlkWords-1] <= {w_q[shs_pkg::BlkWords-1][23:0], ctl_i.byte_val};
    end else if (ctl_i.step) begin
      for (int i = 0; i < shs_pkg::BlkWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[shs_pkg::BlkWords-1] <= w_new;
    end
  end

  assign w0_o = w_q[0];

endmodule

// ----- sv/shs_round.sv -----
`timescale 1ns / 1ps

module shs_round (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  shs_pkg::round_ctl_t       ctl_i,
  input  logic [shs_pkg::WordW-1:0] hash_i [shs_pkg::HashWords],
  input  logic [shs_pkg::WordW-1:0] k_i,
  input  logic [shs_pkg::WordW-1:0] w_i,
  output logic [shs_pkg::WordW-1:0] v_o [shs_pkg::HashWords]
);

  logic [shs_pkg::WordW-1:0] v_q [shs_pkg::HashWords];
  logic [shs_pkg::WordW-1:0] t1, t2, big0, big1, choose, major;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // one compression round
  always_comb begin
    big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big1 + choose + k_i + w_i;
    big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big0 + major;
  end

  // working variables a..h
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < shs_pkg::HashWords; i++) v_q[i] <= '0;
    end else if (ctl_i.init) begin
      for (int i = 0; i < shs_pkg::HashWords; i++) v_q[i] <= hash_i[i];
    end else if (ctl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign v_o = v_q;

endmodule

// ----- sv/sha256_stream_hasher_unit.sv -----
`timescale 1ns / 1ps

// channel | handshake              | payload
// --------+------------------------+---------------------------------------------
// in      | in_valid_i/in_ready_o  | byte_value_i, byte_present_i, end_of_message_i
// out     | out_valid_o/out_ready_i| digest_word_o, word_index_o, last_word_o
//
// a word that completes no block and ends no message leaves the unit idle; the 64th byte
// of a block starts a compression: its rounds on the single shared round unit, then a fold
// an end word then runs padding (up to 72 bytes) with one or two compressions, at one
// byte per cycle outside them, then shows eight digest words, one per accepted cycle
// in_ready_o is high only while idle; out stalls simply hold the current digest word
// reset loads the initial hash and clears counters; no clearing pass is needed

module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_ZERO, S_LEN, S_ROUND, S_FOLD, S_OUT
  } state_e;

  localparam logic [5:0] LastOffset = 6'd63;
  localparam logic [5:0] LenOffset  = 6'd56;

  state_e state_q, state_d, resume_q, resume_d;
  logic [5:0]  offset_q, offset_d;
  logic [60:0] count_q, count_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  lidx_q, lidx_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [shs_pkg::WordW-1:0] hash_q [shs_pkg::HashWords];
  logic [shs_pkg::WordW-1:0] v_w [shs_pkg::HashWords];
  logic [shs_pkg::WordW-1:0] w0_w;

  logic        in_fire, out_fire, absorb, wrap;
  logic [7:0]  byte_src;
  logic [63:0] bits_w;
  shs_pkg::sched_ctl_t sched_ctl;
  shs_pkg::round_ctl_t round_ctl;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign bits_w   = {count_q, 3'b000};

  // byte source and absorb strobe for message and padding
  always_comb begin
    byte_src = byte_value_i;
    absorb   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        byte_src = byte_value_i;
        absorb   = in_fire && byte_present_i;
      end
      S_MARK: begin
        byte_src = shs_pkg::PadMark;
        absorb   = 1'b1;
      end
      S_ZERO: begin
        byte_src = 8'h00;
        absorb   = (offset_q != LenOffset);
      end
      S_LEN: begin
        byte_src = 8'((bits_w >> {~lidx_q, 3'b000}));
        absorb   = 1'b1;
      end
      default: begin
        byte_src = 8'h00;
        absorb   = 1'b0;
      end
    endcase
  end

  assign wrap = absorb && (offset_q == LastOffset);

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    offset_d = absorb ? offset_q + 6'd1 : offset_q;
    count_d  = count_q;
    round_d  = round_q;
    lidx_d   = lidx_q;
    oidx_d   = oidx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (byte_present_i) count_d = count_q + 61'd1;
          if (wrap) begin
            state_d  = S_ROUND;
            resume_d = end_of_message_i ? S_MARK : S_IDLE;
          end else if (end_of_message_i) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        state_d  = wrap ? S_ROUND : S_ZERO;
        resume_d = S_ZERO;
      end
      S_ZERO: begin
        if (offset_q == LenOffset) begin
          state_d = S_LEN;
          lidx_d  = 3'd0;
        end else if (wrap) begin
          state_d  = S_ROUND;
          resume_d = S_ZERO;
        end
      end
      S_LEN: begin
        lidx_d = lidx_q + 3'd1;
        if (lidx_q == 3'd7) begin
          state_d  = S_ROUND;
          resume_d = S_OUT;
        end
      end
      S_ROUND: begin
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) state_d = S_FOLD;
      end
      S_FOLD: begin
        state_d = resume_q;
        oidx_d  = 3'd0;
      end
      S_OUT: begin
        if (out_fire) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = S_IDLE;
            count_d = '0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state, counters and hash words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      resume_q <= S_IDLE;
      offset_q <= '0;
      count_q  <= '0;
      round_q  <= '0;
      lidx_q   <= '0;
      oidx_q   <= '0;
      for (int i = 0; i < shs_pkg::HashWords; i++) hash_q[i] <= shs_pkg::InitHash[i];
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      offset_q <= offset_d;
      count_q  <= count_d;
      round_q  <= round_d;
      lidx_q   <= lidx_d;
      oidx_q   <= oidx_d;
      if (state_q == S_FOLD) begin
        for (int i = 0; i < shs_pkg::HashWords; i++) hash_q[i] <= hash_q[i] + v_w[i];
      end else if (out_fire && oidx_q == 3'd7) begin
        for (int i = 0; i < shs_pkg::HashWords; i++) hash_q[i] <= shs_pkg::InitHash[i];
      end
    end
  end

  // datapath control
  always_comb begin
    sched_ctl.shift_byte = absorb;
    sched_ctl.byte_val   = byte_src;
    sched_ctl.step       = (state_q == S_ROUND);
    round_ctl.init       = wrap;
    round_ctl.step       = (state_q == S_ROUND);
  end

  shs_sched u_sched (
    .clk_i  (clk_i),
    .ctl_i  (sched_ctl),
    .w0_o   (w0_w)
  );

  shs_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (round_ctl),
    .hash_i (hash_q),
    .k_i    (shs_pkg::RoundK[round_q]),
    .w_i    (w0_w),
    .v_o    (v_w)
  );

  // ports
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = hash_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest pending");

  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_word_o) |=> (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word sequence broken");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_word_o) |=> (in_ready_o && !out_valid_o))
    else $error("not idle after last digest word");

  a_len_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN && lidx_q == 3'd7) |-> (offset_q == LastOffset))
    else $error("length field not at block end");

endmodule

// ----- dv/tb_sha256_stream_hasher_unit.sv -----
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_unit;

  // known digests: empty message and the three-byte message "abc"
  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;
  localparam logic [7:0] PadByte     = 8'h80;
  localparam int         RandItems   = 220;
  localparam int         CalmItems   = 180;
  localparam int         PauseItems  = 110;
  localparam int         NumDirected = 16;

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IvTab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  typedef struct packed {
    logic [7:0]   val;
    logic         present;
    logic         eom;
    logic         known;
    logic [255:0] dig;
  } stim_row_t;

  // directed words; digests typed in only for the well-known messages
  stim_row_t dir_rows [NumDirected] = '{
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},        // idle word, ignored
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},   // empty message right after reset
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},     // end carried on the last byte
    '{8'ha5, 1'b0, 1'b1, 1'b1, EmptyDigest},   // empty message right after a digest
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},        // idle word inside a message
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h3c, 1'b0, 1'b1, 1'b0, 256'h0},        // bare end marker
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h55, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'haa, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  int long_lens [6] = '{55, 56, 63, 64, 119, 120};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // hashing state of the predictor
  logic [31:0] hash_regs [8];
  logic [31:0] blk_regs [16];
  logic [5:0]  blk_fill;
  logic [60:0] msg_bytes;

  digest_exp_t digest_q [$];
  int  err_count   = 0;
  int  items_sent  = 0;
  int  bytes_sent  = 0;
  int  msgs_done   = 0;
  int  words_seen  = 0;
  bit  calm        = 1'b0;

  sha256_stream_hasher_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_regs[i] = IvTab[i];
    blk_fill  = '0;
    msg_bytes = '0;
  endfunction

  // 64-round compression of the current block into the running hash
  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_regs[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = hash_regs[0]; b = hash_regs[1]; c = hash_regs[2]; d = hash_regs[3];
    e = hash_regs[4]; f = hash_regs[5]; g = hash_regs[6]; h = hash_regs[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + KTab[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_regs[0] += a; hash_regs[1] += b; hash_regs[2] += c; hash_regs[3] += d;
    hash_regs[4] += e; hash_regs[5] += f; hash_regs[6] += g; hash_regs[7] += h;
  endfunction

  // big-endian byte packing, compress on a full block
  function automatic void load_byte(input logic [7:0] val);
    if (blk_fill[1:0] == 2'd0)
      blk_regs[blk_fill[5:2]] = {val, 24'h0};
    else
      blk_regs[blk_fill[5:2]] |= 32'(val) << ((3 - blk_fill[1:0]) * 8);
    blk_fill++;
    if (blk_fill == 6'd0) compress_blk();
  endfunction

  // one accepted word; returns 1 with the digest when the message ends
  function automatic bit hash_step(input logic [7:0] val, input logic present,
                                   input logic eom, output logic [255:0] dig);
    logic [63:0] bit_len;
    dig = '0;
    if (present) begin
      load_byte(val);
      msg_bytes++;
    end
    if (!eom) return 1'b0;
    bit_len = {msg_bytes, 3'b000};
    load_byte(PadByte);
    while (blk_fill != 6'd56) load_byte(8'h00);
    for (int k = 7; k >= 0; k--) load_byte(bit_len[8*k +: 8]);
    for (int k = 0; k < 8; k++) dig[255-32*k -: 32] = hash_regs[k];
    restart_hash();
    return 1'b1;
  endfunction

  // drive one word, wait for acceptance, queue its digest, maybe idle afterwards
  task automatic send_word(input logic [7:0] val, input logic present, input logic eom,
                           input logic known, input logic [255:0] known_dig);
    logic [255:0] dig;
    digest_exp_t  exp_w;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    byte_value_i     <= val;
    byte_present_i   <= present;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (hash_step(val, present, eom, dig)) begin
      if (known) dig = known_dig;
      for (int k = 0; k < 8; k++) begin
        exp_w.word = dig[255-32*k -: 32];
        exp_w.idx  = 3'(k);
        exp_w.last = (k == 7);
        digest_q.insert(digest_q.size(), exp_w);
      end
      msgs_done++;
    end
    items_sent++;
    if (present) bytes_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver stalls in bursts until the calm tail
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // compare each accepted digest word with the oldest expectation
  always @(posedge clk_i) begin : check_out
    digest_exp_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b",
                 $time, digest_word_o, word_index_o, last_word_o);
        err_count++;
      end else begin
        exp_w = digest_q.pop_front();
        if (digest_word_o !== exp_w.word) begin
          $display("%0t: digest word mismatch, expected %h actual %h",
                   $time, exp_w.word, digest_word_o);
          err_count++;
        end
        if (word_index_o !== exp_w.idx) begin
          $display("%0t: word index mismatch, expected %0d actual %0d",
                   $time, exp_w.idx, word_index_o);
          err_count++;
        end
        if (last_word_o !== exp_w.last) begin
          $display("%0t: last word flag mismatch, expected %0b actual %0b",
                   $time, exp_w.last, last_word_o);
          err_count++;
        end
      end
    end
  end

  // stimulus: directed table, then random messages
  initial begin : stimulus
    int  len;
    bit  sep_end;
    bit  paused;
    int  waited;
    in_valid_i       = 1'b0;
    byte_value_i     = '0;
    byte_present_i   = 1'b0;
    end_of_message_i = 1'b0;
    rst_ni           = 1'b0;
    paused           = 1'b0;
    restart_hash();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++)
      send_word(dir_rows[i].val, dir_rows[i].present, dir_rows[i].eom,
                dir_rows[i].known, dir_rows[i].dig);
    // hold the sender until every digest is out
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    // random messages: mostly short, some across block and padding boundaries
    while (items_sent < RandItems) begin
      if (items_sent >= CalmItems) calm = 1'b1;
      if (!paused && items_sent >= PauseItems) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
      len = ($urandom_range(0, 3) == 0) ? long_lens[$urandom_range(0, 5)]
                                        : $urandom_range(0, 12);
      // keep the total word count near the target
      if (items_sent + len > RandItems) len = $urandom_range(0, 12);
      sep_end = (len == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_word(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_word(8'($urandom), 1'b1, !sep_end && (i == len - 1), 1'b0, '0);
      end
      if (sep_end) send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    waited = 0;
    while (digest_q.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    if (digest_q.size() != 0) begin
      $display("%0t: %0d expected digest words never arrived", $time, digest_q.size());
      err_count++;
    end
    repeat (250) @(posedge clk_i);

    $display("hashed %0d messages from %0d bytes, %0d digest words checked",
             msgs_done, bytes_sent, words_seen);
    $display("including empty messages, known-answer vectors and two-block padding");
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/shs_pkg.sv
sv/shs_sched.sv
sv/shs_round.sv
sv/sha256_stream_hasher_unit.sv
dv/tb_sha256_stream_hasher_unit.sv
